// ===== hdl/ehsb_pkg.sv =====
// shared types, command codes and register indexes for the host port flash bridge
`timescale 1ns / 1ps

package ehsb_pkg;

    // host access kinds
    typedef enum logic [1:0] {
        KIND_WR_CMD    = 2'd0,
        KIND_WR_DATA   = 2'd1,
        KIND_RD_DATA   = 2'd2,
        KIND_RD_STATUS = 2'd3
    } kind_t;

    // pending second byte
    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_FLASH   = 2'd1,
        PEND_VERSION = 2'd2
    } pend_t;

    // host commands
    localparam logic [7:0] CMD_ENTER_FLASH = 8'hDC;
    localparam logic [7:0] CMD_EXIT_FLASH  = 8'hFC;
    localparam logic [7:0] CMD_VERSION     = 8'h80;
    localparam logic [7:0] CMD_SELECT      = 8'h01;
    localparam logic [7:0] CMD_SEND_CMD    = 8'h02;
    localparam logic [7:0] CMD_SEND_BYTE   = 8'h03;
    localparam logic [7:0] CMD_READ_BYTE   = 8'h04;
    localparam logic [7:0] CMD_DESELECT    = 8'h05;

    // version indexes
    localparam logic [7:0] VER_IDX_MAIN = 8'd0;
    localparam logic [7:0] VER_IDX_SUB  = 8'd1;
    localparam logic [7:0] VER_IDX_TEST = 8'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_SUB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_TEST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_MODE_ACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_FILL_BYTE = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_FLASH_MODE_ACK = 8'h33;

    typedef struct packed {
        logic [7:0] version_main;
        logic [7:0] version_sub;
        logic [7:0] version_test;
        logic [7:0] flash_mode_ack;
        logic [7:0] read_fill_byte;
    } cfg_t;

    typedef struct packed {
        logic       in_flash_mode;
        logic       select_active;
        pend_t      pending_byte;
        logic [7:0] out_buffer;
        logic       out_full;
    } bridge_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       spi_shift;
        logic [7:0] spi_byte;
        logic       chip_select;
        logic       cs_restart;
        logic       flash_mode_on;
        logic       access_status;
    } result_t;

endpackage

// ===== hdl/ehsb_decode.sv =====
// access decoder: next bridge state and result for one host access
`timescale 1ns / 1ps

module ehsb_decode
(
    input  ehsb_pkg::cfg_t          cfg,
    input  ehsb_pkg::bridge_state_t cur,
    input  ehsb_pkg::kind_t         kind,
    input  logic [7:0]              bus_byte,
    input  logic [7:0]              flash_reply,
    output ehsb_pkg::bridge_state_t nxt,
    output ehsb_pkg::result_t       res
);

    logic       shift;
    logic [7:0] sbyte;
    logic       restart;
    logic       status;
    logic [7:0] rd;

    always_comb
    begin
        nxt     = cur;
        shift   = 1'b0;
        sbyte   = 8'h00;
        restart = 1'b0;
        status  = 1'b0;
        rd      = 8'h00;

        case (kind)
            ehsb_pkg::KIND_WR_CMD:
            begin
                if (cur.pending_byte == ehsb_pkg::PEND_FLASH)
                begin
                    // second byte of a flash send goes out unchanged
                    shift            = 1'b1;
                    sbyte            = bus_byte;
                    nxt.pending_byte = ehsb_pkg::PEND_NONE;
                end
                else
                begin
                    // a new command drops any version request
                    nxt.pending_byte = ehsb_pkg::PEND_NONE;
                    case (bus_byte)
                        ehsb_pkg::CMD_ENTER_FLASH:
                        begin
                            nxt.in_flash_mode = 1'b1;
                            nxt.out_buffer    = cfg.flash_mode_ack;
                            nxt.out_full      = 1'b1;
                        end
                        ehsb_pkg::CMD_EXIT_FLASH:
                        begin
                            nxt.in_flash_mode = 1'b0;
                            nxt.select_active = 1'b0;
                        end
                        ehsb_pkg::CMD_VERSION:
                        begin
                            nxt.pending_byte = ehsb_pkg::PEND_VERSION;
                        end
                        ehsb_pkg::CMD_SELECT:
                        begin
                            if (!cur.in_flash_mode)
                            begin
                                status = 1'b1;
                            end
                            else
                            begin
                                restart           = cur.select_active;
                                nxt.select_active = 1'b1;
                            end
                        end
                        ehsb_pkg::CMD_DESELECT:
                        begin
                            if (!cur.in_flash_mode)
                            begin
                                status = 1'b1;
                            end
                            else
                            begin
                                nxt.select_active = 1'b0;
                            end
                        end
                        ehsb_pkg::CMD_READ_BYTE:
                        begin
                            if (!cur.in_flash_mode)
                            begin
                                status = 1'b1;
                            end
                            else
                            begin
                                shift          = 1'b1;
                                sbyte          = cfg.read_fill_byte;
                                nxt.out_buffer = flash_reply;
                                nxt.out_full   = 1'b1;
                            end
                        end
                        ehsb_pkg::CMD_SEND_CMD,
                        ehsb_pkg::CMD_SEND_BYTE:
                        begin
                            if (!cur.in_flash_mode)
                            begin
                                status = 1'b1;
                            end
                            else
                            begin
                                nxt.pending_byte = ehsb_pkg::PEND_FLASH;
                            end
                        end
                        default:
                        begin
                            status = 1'b1;
                        end
                    endcase
                end
            end
            ehsb_pkg::KIND_WR_DATA:
            begin
                if (cur.pending_byte == ehsb_pkg::PEND_VERSION)
                begin
                    nxt.pending_byte = ehsb_pkg::PEND_NONE;
                    case (bus_byte)
                        ehsb_pkg::VER_IDX_MAIN:
                        begin
                            nxt.out_buffer = cfg.version_main;
                            nxt.out_full   = 1'b1;
                        end
                        ehsb_pkg::VER_IDX_SUB:
                        begin
                            nxt.out_buffer = cfg.version_sub;
                            nxt.out_full   = 1'b1;
                        end
                        ehsb_pkg::VER_IDX_TEST:
                        begin
                            nxt.out_buffer = cfg.version_test;
                            nxt.out_full   = 1'b1;
                        end
                        default:
                        begin
                            status = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    // stray data write
                    status = 1'b1;
                end
            end
            ehsb_pkg::KIND_RD_DATA:
            begin
                rd           = cur.out_buffer;
                nxt.out_full = 1'b0;
            end
            ehsb_pkg::KIND_RD_STATUS:
            begin
                // bit0 output full, input busy always clear
                rd = {7'd0, cur.out_full};
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase
    end

    // result beat
    always_comb
    begin
        res.read_data     = rd;
        res.spi_shift     = shift;
        res.spi_byte      = sbyte;
        res.chip_select   = nxt.select_active;
        res.cs_restart    = restart;
        res.flash_mode_on = nxt.in_flash_mode;
        res.access_status = status;
    end

endmodule

// ===== hdl/ec_host_port_spi_follow_bridge_unit.sv =====
// top level of the host command/data port to spi flash bridge
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  kind, bus_byte, flash_reply
//  out      output     out_valid/out_stall  read_data, spi_shift, spi_byte, chip_select,
//                                           cs_restart, flash_mode_on, access_status
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// one access per cycle while the output is not stalled: a beat lands in the input register,
// is decoded from there into the result register, so throughput is one beat per
// cycle, set by the single decode step that updates the bridge state
// reset clears the bridge state and both valid flags and loads the register defaults
// a stalled result holds the decode; the input register then stalls the input side
`timescale 1ns / 1ps

module ec_host_port_spi_follow_bridge_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      bus_byte,
    input  logic [7:0]                      flash_reply,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      read_data,
    output logic                            spi_shift,
    output logic [7:0]                      spi_byte,
    output logic                            chip_select,
    output logic                            cs_restart,
    output logic                            flash_mode_on,
    output logic                            access_status,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ehsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);

    ehsb_pkg::cfg_t          cfg_reg;
    ehsb_pkg::bridge_state_t state_reg;
    ehsb_pkg::bridge_state_t state_next;
    ehsb_pkg::result_t       res_reg;
    ehsb_pkg::result_t       res_next;

    logic                    in_valid_reg;
    ehsb_pkg::kind_t         kind_reg;
    logic [7:0]              bus_byte_reg;
    logic [7:0]              flash_reply_reg;
    logic                    out_valid_reg;

    logic                    advance;
    logic                    in_take;

    // decode moves forward when the result register is free or drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version_main   <= 8'h00;
            cfg_reg.version_sub    <= 8'h00;
            cfg_reg.version_test   <= 8'h00;
            cfg_reg.flash_mode_ack <= ehsb_pkg::RST_FLASH_MODE_ACK;
            cfg_reg.read_fill_byte <= 8'h00;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ehsb_pkg::REG_VERSION_MAIN:   cfg_reg.version_main   <= cfg_data;
                ehsb_pkg::REG_VERSION_SUB:    cfg_reg.version_sub    <= cfg_data;
                ehsb_pkg::REG_VERSION_TEST:   cfg_reg.version_test   <= cfg_data;
                ehsb_pkg::REG_FLASH_MODE_ACK: cfg_reg.flash_mode_ack <= cfg_data;
                ehsb_pkg::REG_READ_FILL_BYTE: cfg_reg.read_fill_byte <= cfg_data;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg        <= ehsb_pkg::kind_t'(kind);
            bus_byte_reg    <= bus_byte;
            flash_reply_reg <= flash_reply;
        end
    end

    // access decode
    ehsb_decode u_decode
    (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .kind        (kind_reg),
        .bus_byte    (bus_byte_reg),
        .flash_reply (flash_reply_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // bridge state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // output beat
    assign out_valid     = out_valid_reg;
    assign read_data     = res_reg.read_data;
    assign spi_shift     = res_reg.spi_shift;
    assign spi_byte      = res_reg.spi_byte;
    assign chip_select   = res_reg.chip_select;
    assign cs_restart    = res_reg.cs_restart;
    assign flash_mode_on = res_reg.flash_mode_on;
    assign access_status = res_reg.access_status;

endmodule
